>>> hdl/hdt_pkg.sv
`timescale 1ns / 1ps

package hdt_pkg;

  localparam int SLOTS = 16;

  localparam int KEY_W  = 16;
  localparam int CFG_W  = 5;
  localparam int SLOT_W = 4;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int M_W   = $clog2(SLOTS + 1);
  localparam int PC_W  = $clog2(SLOTS + 2);
  localparam int EXT_W = (CFG_W > M_W) ? CFG_W : M_W;

  localparam int MIN_SIZE = 3;
  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = CFG_W'(15);

  localparam int REM_BITS_PER_CYCLE = 4;
  localparam int REM_CYCLES         = KEY_W / REM_BITS_PER_CYCLE;
  localparam int REM_CNT_W          = $clog2(REM_CYCLES + 1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
  } req_item_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic              table_full;
  } rsp_item_t;

endpackage

>>> hdl/double_hash_key_table.sv
`timescale 1ns / 1ps

// Double-hashing key table with open addressing. An item either inserts a key into the first
// empty slot on its probe path (home slot key mod M, then steps of 1 + key mod (M - 2) taken
// backward with wraparound, M being table_size held to 3..SLOTS) or looks a key up over the home
// slot and M further probes, and gives one result item: found, slot and table_full. One item is
// worked on at a time; req_stall stays high until its result is in the output register, and the
// next item may be accepted while that result waits. Both remainders come from one shared unit
// that takes four key bits a cycle and hashes after acceptance; an insert then checks one slot
// a cycle from the used bits, and a lookup reads one slot key a cycle from the key memory, whose
// read data is registered. A finished result waits in ST_PUT while the output register holds a
// stalled result. The used bits are cleared at reset with no clearing pass.
module double_hash_key_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [hdt_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  hdt_pkg::req_item_t         req_item,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output hdt_pkg::rsp_item_t         rsp_item
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REM_HOME,
    ST_REM_STEP,
    ST_INS,
    ST_LOOK,
    ST_PUT
  } state_t;

  state_t                      state;
  logic [hdt_pkg::CFG_W-1:0]   table_size;
  logic [hdt_pkg::SLOTS-1:0]   slot_used;
  logic                        kind_q;
  logic [hdt_pkg::KEY_W-1:0]   key_q;
  logic [hdt_pkg::M_W-1:0]     m_q;
  logic [hdt_pkg::IDX_W-1:0]   idx;
  logic [hdt_pkg::IDX_W-1:0]   idx_next;
  logic [hdt_pkg::M_W-1:0]     step;
  logic [hdt_pkg::PC_W-1:0]    cnt;
  logic                        rd_pend;
  logic [hdt_pkg::IDX_W-1:0]   rd_idx;
  hdt_pkg::rsp_item_t          res;

  logic [hdt_pkg::M_W-1:0]     m_eff;
  logic [hdt_pkg::M_W-1:0]     idx_ext;
  logic                        accept;
  logic                        rem_start;
  logic [hdt_pkg::KEY_W-1:0]   rem_dividend;
  logic [hdt_pkg::M_W-1:0]     rem_divisor;
  logic                        rem_done;
  logic [hdt_pkg::M_W-1:0]     rem;
  logic                        ram_we;
  logic [hdt_pkg::KEY_W-1:0]   ram_rdata;
  logic                        issuing;
  logic                        hit;
  logic                        put_ok;

  function automatic logic [hdt_pkg::SLOT_W-1:0] to_slot(input logic [hdt_pkg::IDX_W-1:0] i);
    logic [hdt_pkg::SLOT_W+hdt_pkg::IDX_W-1:0] tmp;
    tmp = {{hdt_pkg::SLOT_W{1'b0}}, i};
    return tmp[hdt_pkg::SLOT_W-1:0];
  endfunction

  // effective size, held to 3..SLOTS
  always_comb begin
    logic [hdt_pkg::EXT_W-1:0] tsx;
    tsx = hdt_pkg::EXT_W'(table_size);
    if (tsx < hdt_pkg::EXT_W'(hdt_pkg::MIN_SIZE)) begin
      m_eff = hdt_pkg::M_W'(hdt_pkg::MIN_SIZE);
    end else if (tsx > hdt_pkg::EXT_W'(hdt_pkg::SLOTS)) begin
      m_eff = hdt_pkg::M_W'(hdt_pkg::SLOTS);
    end else begin
      m_eff = tsx[hdt_pkg::M_W-1:0];
    end
  end

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && (state == ST_IDLE);

  assign rem_start    = accept || ((state == ST_REM_HOME) && rem_done);
  assign rem_dividend = (state == ST_IDLE) ? req_item.key : key_q;
  assign rem_divisor  = (state == ST_IDLE) ? m_eff : (m_q - hdt_pkg::M_W'(2));

  // backward probe step with wraparound
  assign idx_ext = hdt_pkg::M_W'(idx);
  always_comb begin
    logic [hdt_pkg::M_W:0] wrap;
    wrap = {1'b0, idx_ext} + {1'b0, m_q} - {1'b0, step};
    if (idx_ext >= step) begin
      idx_next = hdt_pkg::IDX_W'(idx_ext - step);
    end else begin
      idx_next = hdt_pkg::IDX_W'(wrap);
    end
  end

  assign ram_we  = (state == ST_INS) && !slot_used[idx];
  assign issuing = (cnt != (hdt_pkg::PC_W'(m_q) + hdt_pkg::PC_W'(1)));
  assign hit     = rd_pend && slot_used[rd_idx] && (ram_rdata == key_q);
  assign put_ok  = !rsp_valid || !rsp_stall;

  hdt_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .done     (rem_done),
    .rem      (rem)
  );

  hdt_ram #(
    .WIDTH (hdt_pkg::KEY_W),
    .DEPTH (hdt_pkg::SLOTS)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (key_q),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      table_size <= hdt_pkg::TABLE_SIZE_RESET;
      slot_used  <= '0;
      rsp_valid  <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      if (cfg_write) begin
        table_size <= cfg_data;
      end
      if (rsp_valid && !rsp_stall && (state != ST_PUT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            kind_q <= req_item.kind;
            key_q  <= req_item.key;
            m_q    <= m_eff;
            state  <= ST_REM_HOME;
          end
        end
        ST_REM_HOME: begin
          if (rem_done) begin
            idx   <= hdt_pkg::IDX_W'(rem);
            state <= ST_REM_STEP;
          end
        end
        ST_REM_STEP: begin
          if (rem_done) begin
            step    <= rem + hdt_pkg::M_W'(1);
            cnt     <= '0;
            rd_pend <= 1'b0;
            res     <= '0;
            state   <= (kind_q == hdt_pkg::KIND_INSERT) ? ST_INS : ST_LOOK;
          end
        end
        ST_INS: begin
          if (!slot_used[idx]) begin
            slot_used[idx] <= 1'b1;
            res.found      <= 1'b1;
            res.slot       <= to_slot(idx);
            state          <= ST_PUT;
          end else if (cnt == hdt_pkg::PC_W'(m_q)) begin
            res.table_full <= 1'b1;
            state          <= ST_PUT;
          end else begin
            idx <= idx_next;
            cnt <= cnt + hdt_pkg::PC_W'(1);
          end
        end
        ST_LOOK: begin
          rd_pend <= issuing;
          if (issuing) begin
            rd_idx <= idx;
            idx    <= idx_next;
            cnt    <= cnt + hdt_pkg::PC_W'(1);
          end
          if (hit) begin
            res.found <= 1'b1;
            res.slot  <= to_slot(rd_idx);
            state     <= ST_PUT;
          end else if (!issuing) begin
            state <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (put_ok) begin
            rsp_item  <= res;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_done_when_hashing: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> (state == ST_REM_HOME || state == ST_REM_STEP))
    else $error("remainder finished outside hashing");

  a_write_empty_slot: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> slot_used[$past(idx)])
    else $error("inserted slot not marked used");

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS || state == ST_LOOK) |-> (idx_ext < m_q))
    else $error("probe index beyond table size");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUT && put_ok) |=> (state == ST_IDLE && rsp_valid))
    else $error("result item not loaded");

  a_found_not_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_item.found && rsp_item.table_full))
    else $error("result both found and full");
`endif

endmodule

>>> hdl/hdt_ram.sv
`timescale 1ns / 1ps

module hdt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/hdt_rem_unit.sv
`timescale 1ns / 1ps

module hdt_rem_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [hdt_pkg::KEY_W-1:0] dividend,
  input  logic [hdt_pkg::M_W-1:0]   divisor,
  output logic                     done,
  output logic [hdt_pkg::M_W-1:0]   rem
);

  logic [hdt_pkg::KEY_W-1:0]     shreg;
  logic [hdt_pkg::KEY_W-1:0]     shreg_next;
  logic [hdt_pkg::M_W-1:0]       rem_next;
  logic [hdt_pkg::M_W-1:0]       dvs;
  logic [hdt_pkg::REM_CNT_W-1:0] cnt;

  // restoring remainder, several dividend bits per cycle
  always_comb begin
    logic [hdt_pkg::M_W:0] t;
    rem_next   = rem;
    shreg_next = shreg;
    for (int k = 0; k < hdt_pkg::REM_BITS_PER_CYCLE; k++) begin
      t = {rem_next, shreg_next[hdt_pkg::KEY_W-1]};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
      end
      rem_next   = t[hdt_pkg::M_W-1:0];
      shreg_next = {shreg_next[hdt_pkg::KEY_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt   <= hdt_pkg::REM_CNT_W'(hdt_pkg::REM_CYCLES);
      done  <= 1'b0;
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (cnt != '0) begin
      cnt   <= cnt - hdt_pkg::REM_CNT_W'(1);
      done  <= (cnt == hdt_pkg::REM_CNT_W'(1));
      shreg <= shreg_next;
      rem   <= rem_next;
    end else begin
      done <= 1'b0;
    end
  end

endmodule
